[rtl/core/lrt_pkg.sv]
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types, codes and defaults for the LRU replacement tracker.
// ----------------------------------------------------------------------------
package lrt_pkg;

    localparam int ACTION_W     = 2;
    localparam int KEY_W        = 16;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 7;

    localparam int ENTRIES_DEF  = 64;
    localparam int KEY_BITS_DEF = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_EVICT  = 2'd1,
        ACT_ERASE  = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // Table update applied in the final step of a transaction
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TOUCH,
        OP_INSERT,
        OP_ERASE,
        OP_EVICT
    } t_apply_op;

    typedef struct packed {
        logic      capture;   // latch the incoming key
        logic      match;     // build hit and free vectors
        logic      by_rank;   // match on the oldest rank instead of the key
        logic      select;    // pick rank and key of the hit slot
        logic      apply;     // update the table and load the result
        t_apply_op op;
        t_status   status;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

[rtl/core/lrt_datapath.sv]
// ----------------------------------------------------------------------------
// lrt_datapath
// Slot array with per-slot key compare, age ranks, occupancy and result regs.
// ----------------------------------------------------------------------------
module lrt_datapath #(
    parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lrt_pkg::KEY_W-1:0]  i_key,
    input  lrt_pkg::t_dp_cmd           i_cmd,
    output lrt_pkg::t_dp_stat          o_stat,
    output logic [lrt_pkg::STATUS_W-1:0] o_status,
    output logic [lrt_pkg::KEY_W-1:0]  o_victim_key,
    output logic [lrt_pkg::OCC_W-1:0]  o_occupancy
);
    import lrt_pkg::*;

    localparam int RANK_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_slot_key  [ENTRIES];
    logic [RANK_W-1:0]   r_slot_rank [ENTRIES];
    logic [ENTRIES-1:0]  r_slot_valid;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [ENTRIES-1:0]  r_hit;
    logic [ENTRIES-1:0]  r_free;
    logic [RANK_W-1:0]   r_sel_rank;
    logic [KEY_BITS-1:0] r_sel_key;
    logic [RANK_W-1:0]   n_sel_rank;
    logic [KEY_BITS-1:0] n_sel_key;
    logic [RANK_W-1:0]   last_rank;
    logic [STATUS_W-1:0] r_status;
    logic [KEY_W-1:0]    r_victim;
    logic [OCC_W-1:0]    r_occ;

    assign last_rank = RANK_W'(r_count - CNT_W'(1));

    // Hit vector is one-hot at most, so a plain OR picks the selected slot
    always_comb begin
        n_sel_rank = '0;
        n_sel_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_hit[i]) begin
                n_sel_rank = n_sel_rank | r_slot_rank[i];
                n_sel_key  = n_sel_key | r_slot_key[i];
            end
        end
    end

    always_comb begin
        unique case (i_cmd.op)
            OP_INSERT:         n_count = r_count + CNT_W'(1);
            OP_ERASE, OP_EVICT: n_count = r_count - CNT_W'(1);
            default:           n_count = r_count;
        endcase
    end

    // Control state: valid bits and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_count      <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_cmd.op == OP_INSERT && r_free[i]) begin
                    r_slot_valid[i] <= 1'b1;
                end else if ((i_cmd.op == OP_ERASE || i_cmd.op == OP_EVICT) && r_hit[i]) begin
                    r_slot_valid[i] <= 1'b0;
                end
            end
        end
    end

    // Payload: keys, ranks, search vectors and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key <= KEY_BITS'(i_key);
        end
        if (i_cmd.match) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_cmd.by_rank) begin
                    r_hit[i] <= r_slot_valid[i] && (r_slot_rank[i] == last_rank);
                end else begin
                    r_hit[i] <= r_slot_valid[i] && (r_slot_key[i] == r_key);
                end
            end
            r_free <= ~r_slot_valid & (r_slot_valid + ENTRIES'(1));
        end
        if (i_cmd.select) begin
            r_sel_rank <= n_sel_rank;
            r_sel_key  <= n_sel_key;
        end
        if (i_cmd.apply) begin
            for (int i = 0; i < ENTRIES; i++) begin
                unique case (i_cmd.op)
                    OP_TOUCH: begin
                        if (r_hit[i]) begin
                            r_slot_rank[i] <= '0;
                        end else if (r_slot_valid[i] && r_slot_rank[i] < r_sel_rank) begin
                            r_slot_rank[i] <= r_slot_rank[i] + RANK_W'(1);
                        end
                    end
                    OP_INSERT: begin
                        if (r_free[i]) begin
                            r_slot_key[i]  <= r_key;
                            r_slot_rank[i] <= '0;
                        end else if (r_slot_valid[i]) begin
                            r_slot_rank[i] <= r_slot_rank[i] + RANK_W'(1);
                        end
                    end
                    OP_ERASE, OP_EVICT: begin
                        if (r_slot_valid[i] && r_slot_rank[i] > r_sel_rank) begin
                            r_slot_rank[i] <= r_slot_rank[i] - RANK_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            r_status <= i_cmd.status;
            r_victim <= (i_cmd.op == OP_EVICT) ? KEY_W'(r_sel_key) : '0;
            r_occ    <= OCC_W'(n_count);
        end
    end

    assign o_stat.hit   = |r_hit;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(ENTRIES));

    assign o_status     = r_status;
    assign o_victim_key = r_victim;
    assign o_occupancy  = r_occ;

endmodule

[rtl/core/lrt_ctrl.sv]
// ----------------------------------------------------------------------------
// lrt_ctrl
// Transaction sequencer: capture, match, select, apply; owns both handshakes.
// ----------------------------------------------------------------------------
module lrt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lrt_pkg::ACTION_W-1:0]  i_action,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  lrt_pkg::t_dp_stat             i_stat,
    output lrt_pkg::t_dp_cmd              o_cmd
);
    import lrt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_SELECT,
        S_APPLY
    } t_state;

    t_state                r_state;
    logic [ACTION_W-1:0]   r_action;
    logic                  r_out_valid;
    logic                  out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = OP_NONE;
        o_cmd.status  = ST_DONE;
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.match   = (r_state == S_MATCH);
        o_cmd.by_rank = (r_action == ACT_EVICT);
        o_cmd.select  = (r_state == S_SELECT);
        o_cmd.apply   = (r_state == S_APPLY) && out_free;
        unique case (r_action)
            ACT_INSERT: begin
                if (i_stat.hit) begin
                    o_cmd.op = OP_TOUCH;
                end else if (i_stat.full) begin
                    o_cmd.status = ST_FULL;
                end else begin
                    o_cmd.op = OP_INSERT;
                end
            end
            ACT_EVICT: begin
                if (i_stat.empty || !i_stat.hit) begin
                    o_cmd.status = ST_ABSENT;
                end else begin
                    o_cmd.op = OP_EVICT;
                end
            end
            ACT_ERASE: begin
                if (i_stat.hit) begin
                    o_cmd.op = OP_ERASE;
                end else begin
                    o_cmd.status = ST_ABSENT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Raise the result flag on apply, drop it once the result is taken
            if ((r_state == S_APPLY) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH:  r_state <= S_SELECT;
                S_SELECT: r_state <= S_APPLY;
                S_APPLY: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_action <= i_action;
        end
    end

endmodule

[rtl/core/lru_replacement_tracker_unit.sv]
// ----------------------------------------------------------------------------
// lru_replacement_tracker_unit
// Recency-ordered set of up to ENTRIES keys with insert, evict and erase.
// ----------------------------------------------------------------------------
// Each transaction passes through these steps from acceptance to the next
// possible acceptance: capture the request, compare the key against every
// slot in parallel (or, for an evict, find the slot holding the oldest
// rank), pick out the rank and key of the matching slot, and then update
// the age ranks of the slots and load the result register. The
// input side is ready again while the result waits; if the previous result
// has not been taken by the time the update is due, the update holds until it
// is. Every result carries the occupancy after the transaction. An insert of
// a key already present moves it to most recently used; an insert of a new
// key into a full table is refused with status full. An evict on an empty
// table and an erase of an absent key return status absent. Action code 3 is
// a no-op that returns status done. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module lru_replacement_tracker_unit #(
    parameter int ENTRIES  = lrt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = lrt_pkg::KEY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [lrt_pkg::ACTION_W-1:0]    i_action,
    input  logic [lrt_pkg::KEY_W-1:0]       i_key,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [lrt_pkg::STATUS_W-1:0]    o_status,
    output logic [lrt_pkg::KEY_W-1:0]       o_victim_key,
    output logic [lrt_pkg::OCC_W-1:0]       o_occupancy
);
    import lrt_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer: advance each transaction through match, select and apply
    lrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Slot table: keys, valid bits, age ranks, occupancy and result register
    lrt_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (i_key),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_status     (o_status),
        .o_victim_key (o_victim_key),
        .o_occupancy  (o_occupancy)
    );

endmodule

[verif/tb_lru_replacement_tracker_unit.sv]
// ----------------------------------------------------------------------------
// tb_lru_replacement_tracker_unit
// Self-checking bench for the LRU replacement tracker: a queue-fed driver and
// a clocked monitor compare every result against an in-bench recency model.
// ----------------------------------------------------------------------------
module tb_lru_replacement_tracker_unit;

    import lrt_pkg::*;

    localparam int N_SLOTS     = ENTRIES_DEF;
    localparam int REQ_TOTAL   = 1675;     // directed part plus random part
    localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
    localparam int SETTLE      = 16;

    // Action code 3 carries no operation in the package enum
    localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        bit                  drain_first;  // hold off until all results are back
        int                  phase;        // selects the idle rates
    } t_lru_req;

    typedef struct {
        t_status          status;
        logic [KEY_W-1:0] victim;
        logic [OCC_W-1:0] occ;
    } t_lru_result;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [ACTION_W-1:0] i_action   = '0;
    logic [KEY_W-1:0]    i_key      = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [KEY_W-1:0]    o_victim_key;
    logic [OCC_W-1:0]    o_occupancy;

    lru_replacement_tracker_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_victim_key (o_victim_key),
        .o_occupancy  (o_occupancy)
    );

    // ------------------------------------------------------------------------
    // Recency model: its own copy of the table, reset once with the block
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0] trk_key   [N_SLOTS];
    logic             trk_valid [N_SLOTS] = '{default: 1'b0};
    logic [5:0]       trk_rank  [N_SLOTS];
    logic [OCC_W-1:0] trk_count = '0;

    t_lru_req         req_q[$];
    t_lru_result      expected_results[$];
    logic [KEY_W-1:0] known_keys[$];
    t_lru_req         drv_req;
    t_lru_result      got_res;
    int               cur_phase     = 0;
    int               reqs_accepted = 0;
    int               err_count     = 0;
    int               cycle_count   = 0;

    // Apply one transaction to the model and return the result it must produce
    function automatic t_lru_result lru_apply(input logic [ACTION_W-1:0] act,
                                              input logic [KEY_W-1:0] key_in);
        t_lru_result res;
        int          hit;
        int          free_slot;
        logic [5:0]  r;
        res.status = ST_DONE;
        res.victim = '0;
        hit        = -1;
        free_slot  = -1;
        for (int i = N_SLOTS - 1; i >= 0; i--) begin
            if (trk_valid[i] && trk_key[i] == key_in) hit = i;
            if (!trk_valid[i]) free_slot = i;   // lowest free slot wins
        end
        case (act)
            ACT_INSERT: begin
                if (hit >= 0) begin
                    // Touch: keys more recent than this one age by one
                    r = trk_rank[hit];
                    for (int i = 0; i < N_SLOTS; i++)
                        if (trk_valid[i] && trk_rank[i] < r) trk_rank[i]++;
                    trk_rank[hit] = '0;
                end else if (trk_count >= N_SLOTS || free_slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = 0; i < N_SLOTS; i++)
                        if (trk_valid[i]) trk_rank[i]++;
                    trk_key[free_slot]   = key_in;
                    trk_valid[free_slot] = 1'b1;
                    trk_rank[free_slot]  = '0;
                    trk_count++;
                end
            end
            ACT_EVICT: begin
                if (trk_count == 0) begin
                    res.status = ST_ABSENT;
                end else begin
                    hit = -1;
                    for (int i = 0; i < N_SLOTS; i++)
                        if (trk_valid[i] && trk_rank[i] == trk_count - 1) hit = i;
                    if (hit < 0) begin
                        res.status = ST_ABSENT;
                    end else begin
                        res.victim     = trk_key[hit];
                        trk_valid[hit] = 1'b0;
                        trk_count--;
                    end
                end
            end
            ACT_ERASE: begin
                if (hit < 0) begin
                    res.status = ST_ABSENT;
                end else begin
                    r = trk_rank[hit];
                    for (int i = 0; i < N_SLOTS; i++)
                        if (trk_valid[i] && trk_rank[i] > r) trk_rank[i]--;
                    trk_valid[hit] = 1'b0;
                    if (trk_count > 0) trk_count--;
                end
            end
            default: ;  // unused code leaves the table alone
        endcase
        res.occ = trk_count;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------
    function automatic void add_req(input logic [ACTION_W-1:0] act,
                                    input logic [KEY_W-1:0] k, input bit drain);
        t_lru_req rq;
        int       ph;
        if (req_q.size() >= REQ_TOTAL) return;
        ph = (req_q.size() * 3) / REQ_TOTAL;
        if (ph > 2) ph = 2;
        rq.action      = act;
        rq.key         = k;
        // Let the pipeline empty at each change of idle pattern
        rq.drain_first = drain || (req_q.size() != 0 && req_q[$].phase != ph);
        rq.phase       = ph;
        req_q.push_back(rq);
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom_range(16'hFFFF));
        known_keys.push_back(k);
        if (known_keys.size() > 160) void'(known_keys.pop_front());
        return k;
    endfunction

    // Mostly a key the table has seen lately, sometimes any key at all
    function automatic logic [KEY_W-1:0] some_known_key();
        if (known_keys.size() == 0 || $urandom_range(99) < 15)
            return KEY_W'($urandom_range(16'hFFFF));
        return known_keys[$urandom_range(known_keys.size() - 1)];
    endfunction

    task automatic build_requests();
        int kind;
        int len;
        int pick;
        // Directed: empty-table corners, touch at each position, no-op, erase
        add_req(ACT_EVICT,  16'h0000, 1'b0);   // evict on empty table
        add_req(ACT_ERASE,  16'h0000, 1'b0);   // erase of an absent key
        add_req(ACT_NOP,    16'hFFFF, 1'b0);   // unused action code
        add_req(ACT_INSERT, 16'h0000, 1'b0);
        add_req(ACT_INSERT, 16'hFFFF, 1'b0);
        add_req(ACT_INSERT, 16'h5A5A, 1'b0);
        add_req(ACT_INSERT, 16'hA5A5, 1'b0);
        add_req(ACT_INSERT, 16'h0000, 1'b0);   // touch the oldest key
        add_req(ACT_INSERT, 16'h5A5A, 1'b0);   // touch a middle key
        add_req(ACT_INSERT, 16'h5A5A, 1'b0);   // touch the newest key
        add_req(ACT_NOP,    16'h1234, 1'b0);
        add_req(ACT_ERASE,  16'hFFFF, 1'b0);
        add_req(ACT_ERASE,  16'h1111, 1'b0);
        add_req(ACT_EVICT,  16'h7777, 1'b0);
        add_req(ACT_EVICT,  16'h0000, 1'b0);
        add_req(ACT_EVICT,  16'h0000, 1'b0);
        add_req(ACT_EVICT,  16'h0000, 1'b0);   // empty again
        add_req(ACT_INSERT, 16'h8001, 1'b0);
        add_req(ACT_ERASE,  16'h8001, 1'b0);   // erase the only key
        add_req(ACT_EVICT,  16'hFFFF, 1'b0);

        // Random episodes: fill to full and past it, mixed traffic, drains,
        // and a little unstructured noise
        while (req_q.size() < REQ_TOTAL) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                len = $urandom_range(90, 40);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < 85) add_req(ACT_INSERT, fresh_key(), 1'b0);
                    else                         add_req(ACT_INSERT, some_known_key(), 1'b0);
                end
            end else if (kind < 65) begin
                len = $urandom_range(60, 20);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(99);
                    if (pick < 25)      add_req(ACT_INSERT, fresh_key(), 1'b0);
                    else if (pick < 50) add_req(ACT_INSERT, some_known_key(), 1'b0);
                    else if (pick < 70) add_req(ACT_EVICT,
                                                KEY_W'($urandom_range(16'hFFFF)), 1'b0);
                    else if (pick < 95) add_req(ACT_ERASE, some_known_key(), 1'b0);
                    else                add_req(ACT_NOP,
                                                KEY_W'($urandom_range(16'hFFFF)), 1'b0);
                end
            end else if (kind < 85) begin
                len = $urandom_range(80, 30);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < 75)
                        add_req(ACT_EVICT, KEY_W'($urandom_range(16'hFFFF)), 1'b0);
                    else
                        add_req(ACT_ERASE, some_known_key(), 1'b0);
                end
            end else begin
                len = $urandom_range(20, 5);
                for (int i = 0; i < len; i++)
                    add_req(ACTION_W'($urandom_range(3)),
                            KEY_W'($urandom_range(16'hFFFF)), 1'b0);
            end
            // Now and then hold the last request of this episode until the tracker is drained
            if ($urandom_range(99) < 5 && req_q.size() != 0) req_q[$].drain_first = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        build_requests();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: predict on acceptance, then present the next request or idle
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_action   <= '0;
            i_key      <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(lru_apply(i_action, i_key));
                reqs_accepted++;
            end
            // Only change the payload once the current transaction is gone
            if (!i_in_valid || o_in_ready) begin
                if (req_q.size() != 0
                        && !(req_q[0].drain_first && expected_results.size() != 0)
                        && $urandom_range(99) >= (req_q[0].phase == 0 ? 21 :
                                                  req_q[0].phase == 1 ? 49 : 0)) begin
                    drv_req    = req_q.pop_front();
                    cur_phase  = drv_req.phase;
                    i_in_valid <= 1'b1;
                    i_action   <= drv_req.action;
                    i_key      <= drv_req.key;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    err_count++;
                    $error("result with no transaction outstanding");
                end else begin
                    got_res = expected_results.pop_front();
                    check_field("status",     got_res.status, o_status);
                    check_field("victim_key", got_res.victim, o_victim_key);
                    check_field("occupancy",  got_res.occ,    o_occupancy);
                end
            end
            i_out_ready <= ($urandom_range(99) >= (cur_phase == 0 ? 49 :
                                                    cur_phase == 1 ? 21 : 0));
        end
    end

    // ------------------------------------------------------------------------
    // End of run: every request accepted and answered, then let it settle
    // ------------------------------------------------------------------------
    initial begin
        wait (i_rst_n === 1'b1);
        while (reqs_accepted < REQ_TOTAL || req_q.size() != 0
               || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            err_count++;
            $error("%0d results never arrived", expected_results.size());
        end
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
